### src/button_multi_click_detector_top_macros.svh
// assertion macros for the button multi-click detector checker
// depends on clk and rst_n being visible where the macros are used
`ifndef BUTTON_MULTI_CLICK_DETECTOR_TOP_MACROS_SVH
`define BUTTON_MULTI_CLICK_DETECTOR_TOP_MACROS_SVH

// clocked assertion, off while reset is asserted
`define BMCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that is also checked during reset
`define BMCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### src/bmcd_pkg.sv
// shared types, phase codes and register indexes of the button multi-click detector
// no dependencies
package bmcd_pkg;

    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int CODE_W      = 9;
    localparam int PHASE_W     = 3;
    localparam int CFG_INDEX_W = 3;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_AWAIT_PRESS      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE_PRESS   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_AWAIT_RELEASE    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE_RELEASE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_AWAIT_MULTI      = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DEBOUNCE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DEBOUNCE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MULTI_CLICK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD            = 3'd4;

    // a time register write of all ones is dropped
    localparam logic [LIMIT_W-1:0] LIMIT_KEEP = '1;

    localparam logic [CODE_W-1:0] HOLD_MARK  = '1;
    localparam logic [CODE_W-1:0] COUNT_MAX  = 9'd255;
    localparam logic [CODE_W-1:0] CODE_NONE  = '0;

    typedef struct packed {
        logic               active_level;
        logic [LIMIT_W-1:0] press_debounce_ms;
        logic [LIMIT_W-1:0] release_debounce_ms;
        logic [LIMIT_W-1:0] multi_click_ms;
        logic [LIMIT_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CODE_W-1:0]  click_count;
        logic [TIME_W-1:0]  start_time;
    } state_t;

endpackage

### src/bmcd_cfg.sv
// configuration register file of the button multi-click detector
// depends on bmcd_pkg
module bmcd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmcd_pkg::LIMIT_W-1:0]   cfg_wdata,
    output bmcd_pkg::cfg_t                 cfg
);
    import bmcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic keep_time;

    // time registers ignore the all-ones value
    assign keep_time = (cfg_wdata == LIMIT_KEEP);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL:
                    cfg_next.active_level = cfg_wdata[0];
                REG_PRESS_DEBOUNCE:
                    if (!keep_time) cfg_next.press_debounce_ms = cfg_wdata;
                REG_RELEASE_DEBOUNCE:
                    if (!keep_time) cfg_next.release_debounce_ms = cfg_wdata;
                REG_MULTI_CLICK:
                    if (!keep_time) cfg_next.multi_click_ms = cfg_wdata;
                REG_HOLD:
                    if (!keep_time) cfg_next.hold_ms = cfg_wdata;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level        <= 1'b0;
            cfg_reg.press_debounce_ms   <= 16'd25;
            cfg_reg.release_debounce_ms <= 16'd30;
            cfg_reg.multi_click_ms      <= 16'd300;
            cfg_reg.hold_ms             <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/bmcd_step.sv
// next-state and result logic for one poll of the button
// depends on bmcd_pkg
module bmcd_step (
    input  bmcd_pkg::cfg_t                 cfg,
    input  bmcd_pkg::state_t               state,
    input  logic                           pin_level,
    input  logic [bmcd_pkg::TIME_W-1:0]    now_ms,
    output bmcd_pkg::state_t               state_next,
    output logic signed [bmcd_pkg::CODE_W-1:0] code
);
    import bmcd_pkg::*;

    logic              pressed;
    logic [TIME_W-1:0] elapsed;
    logic              over_press_db;
    logic              over_release_db;
    logic              over_multi;
    logic              over_hold;

    // modular elapsed time and the limit compares
    assign pressed         = (pin_level == cfg.active_level);
    assign elapsed         = now_ms - state.start_time;
    assign over_press_db   = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, cfg.press_debounce_ms};
    assign over_release_db = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, cfg.release_debounce_ms};
    assign over_multi      = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, cfg.multi_click_ms};
    assign over_hold       = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, cfg.hold_ms};

    // phase machine
    always_comb
    begin
        state_next = state;
        code       = CODE_NONE;
        unique case (state.phase)
            PH_DEBOUNCE_PRESS:
            begin
                if (over_press_db)
                begin
                    state_next.phase      = PH_AWAIT_RELEASE;
                    state_next.start_time = now_ms;
                end
            end
            PH_AWAIT_RELEASE:
            begin
                if (!pressed)
                begin
                    if (over_hold)
                        state_next.click_count = HOLD_MARK;
                    state_next.phase      = PH_DEBOUNCE_RELEASE;
                    state_next.start_time = now_ms;
                end
            end
            PH_DEBOUNCE_RELEASE:
            begin
                if (over_release_db)
                begin
                    if (state.click_count == HOLD_MARK)
                    begin
                        state_next.phase = PH_AWAIT_PRESS;
                        code             = HOLD_MARK;
                    end
                    else
                    begin
                        if (state.click_count < COUNT_MAX)
                            state_next.click_count = state.click_count + 9'd1;
                        state_next.phase      = PH_AWAIT_MULTI;
                        state_next.start_time = now_ms;
                    end
                end
            end
            PH_AWAIT_MULTI:
            begin
                if (pressed)
                begin
                    state_next.phase      = PH_DEBOUNCE_PRESS;
                    state_next.start_time = now_ms;
                end
                else if (over_multi)
                begin
                    state_next.phase = PH_AWAIT_PRESS;
                    code             = state.click_count;
                end
            end
            default:
            begin
                // await press, also taken by unused phase codes
                state_next.phase       = PH_AWAIT_PRESS;
                state_next.click_count = '0;
                if (pressed)
                begin
                    state_next.phase      = PH_DEBOUNCE_PRESS;
                    state_next.start_time = now_ms;
                end
            end
        endcase
    end

endmodule

### src/button_multi_click_detector_top.sv
// Button multi-click and long-press detector, one poll per transaction.
// A poll is accepted into the input register and moves on to the result register once that
// register is empty or being read; throughput is one poll per clock while the output is not
// stalled, with the phase update done combinationally between the two registers. Reset puts
// the machine in await press with a zero count and start time, loads the register
// defaults and empties both stages.
module button_multi_click_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pin_level,
    input  logic [bmcd_pkg::TIME_W-1:0]         now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bmcd_pkg::CODE_W-1:0]  click_code,
    input  logic                                cfg_we,
    input  logic [bmcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bmcd_pkg::LIMIT_W-1:0]        cfg_wdata
);
    import bmcd_pkg::*;

    cfg_t                     cfg;
    state_t                   state_reg;
    state_t                   state_next;
    logic                     in_valid_reg;
    logic                     pin_reg;
    logic [TIME_W-1:0]        now_reg;
    logic                     out_valid_reg;
    logic signed [CODE_W-1:0] code_reg;
    logic signed [CODE_W-1:0] code_next;
    logic                     advance;

    // configuration registers
    bmcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // phase update for the registered poll
    bmcd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .pin_level  (pin_reg),
        .now_ms     (now_reg),
        .state_next (state_next),
        .code       (code_next)
    );

    // stage flow control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_level;
            now_reg <= now_ms;
        end
    end

    // machine state, updated as a poll moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_AWAIT_PRESS;
            state_reg.click_count <= '0;
            state_reg.start_time  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            code_reg <= code_next;
    end

    assign out_valid  = out_valid_reg;
    assign click_code = code_reg;

endmodule

### src/bmcd_checker.sv
// port-level checker for the button multi-click detector, bound to the top level
// depends on bmcd_pkg and button_multi_click_detector_top_macros.svh
`include "button_multi_click_detector_top_macros.svh"

module bmcd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [bmcd_pkg::CODE_W-1:0]  click_code
);
    import bmcd_pkg::*;

    // a negative code can only be the long-hold mark
    `BMCD_ASSERT(a_code_range, out_valid && click_code[CODE_W-1] |-> click_code == HOLD_MARK, "click code out of range")

    // the input side stalls only when a result is stuck at the output
    `BMCD_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

    // a stalled result holds its value
    `BMCD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(click_code), "stalled result changed")

    // no result right out of reset
    `BMCD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid during reset")

endmodule

bind button_multi_click_detector_top bmcd_checker u_bmcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .click_code (click_code)
);
